// ===== rtl/hlt_pkg.sv =====
// ----------------------------------------------------------------------------
// hlt_pkg
// Shared types and constants of the heartbeat liveness table: action and
// status codes, controller states, and the records that pass between the
// controller and the row of table cells.
// ----------------------------------------------------------------------------
package hlt_pkg;

  localparam int unsigned ID_W        = 16;
  localparam int unsigned HEART_W     = 8;
  localparam int unsigned OCC_W       = 5;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned KCNT_W      = $clog2(MAX_RESULTS + 1);

  localparam logic [HEART_W-1:0] HEART_MAX = '1;

  localparam logic [1:0] ADDR_LIMIT = 2'd0;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_REMOVE = 3'd1,
    OP_CLEAR  = 3'd2,
    OP_TICK   = 3'd3,
    OP_SWEEP  = 3'd4,
    OP_LOOKUP = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NOTFOUND = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_EMPTY    = 2'd3
  } stat_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH,
    ST_COMPACT
  } st_e;

  typedef struct packed {
    logic               valid;
    logic [ID_W-1:0]    conn;
    logic [ID_W-1:0]    station;
    logic [HEART_W-1:0] heart;
  } entry_t;

  typedef struct packed {
    logic               start;
    logic               walk;
    logic               compact;
    logic               tick;
    logic               wr;
    logic               drop_en;
    op_e                op;
    logic [ID_W-1:0]    conn;
    logic [ID_W-1:0]    station;
    logic [HEART_W-1:0] heart;
    logic [HEART_W-1:0] limit;
  } cmd_t;

  typedef struct packed {
    logic               hit;
    logic [ID_W-1:0]    conn;
    logic [HEART_W-1:0] heart;
  } rep_t;

endpackage

// ===== rtl/heartbeat_liveness_table.sv =====
// ----------------------------------------------------------------------------
// heartbeat_liveness_table
// Insertion-ordered table of connection and station ids with heartbeat
// counts, built as a row of cells under a small sequencer, with an APB
// register for the sweep timeout limit.
//
//   Channel   Signals                                  Handshake
//   request   action_i, connection_id_i, station_id_i, start && !busy
//             initial_heart_i
//   result    status_o, connection_out_o, heart_out_o, result_valid_o strobe,
//             occupancy_o, last_o                      one cycle, no stall
//   config    psel, penable, pwrite, paddr, pwdata,    APB, pready tied high
//             prdata, pready
//
// Add, tick, unused actions, an add on a full table and requests on an empty
// table need no walk: the result appears the cycle after the request and busy
// stays low.
// Remove, clear heartbeat and lookup walk a token over the cells, one cell per
// cycle; a remove then closes its hole by compaction.
// A sweep walks every entry, then a flush state, and, when it drops anything,
// compaction; it emits at most one result per cycle. After reset the table is
// empty and the timeout limit is 5. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module heartbeat_liveness_table
  import hlt_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 16
)(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         action_i,
  input  logic [ID_W-1:0]    connection_id_i,
  input  logic [ID_W-1:0]    station_id_i,
  input  logic [HEART_W-1:0] initial_heart_i,
  output logic               result_valid_o,
  output logic [1:0]         status_o,
  output logic [ID_W-1:0]    connection_out_o,
  output logic [HEART_W-1:0] heart_out_o,
  output logic [OCC_W-1:0]   occupancy_o,
  output logic               last_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam logic [HEART_W-1:0] LIMIT_RESET = 8'd5;

  logic [HEART_W-1:0] limit_q;
  cmd_t               cmd;
  rep_t               rep;
  logic               table_packed;
  entry_t             ent  [MAX_ENTRIES];
  logic               hit  [MAX_ENTRIES];
  logic               tok  [MAX_ENTRIES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_LIMIT) begin
      limit_q <= pwdata[HEART_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_LIMIT) ? {{(32-HEART_W){1'b0}}, limit_q} : '0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic   left_valid;
    logic   tok_in;
    entry_t right;

    if (i == 0) begin : g_first
      assign left_valid = 1'b1;
      assign tok_in     = cmd.start;
    end else begin : g_mid
      assign left_valid = ent[i-1].valid;
      assign tok_in     = tok[i-1];
    end

    if (i == MAX_ENTRIES - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner
      assign right = ent[i+1];
    end

    hlt_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .left_valid_i (left_valid),
      .right_i      (right),
      .tok_i        (tok_in),
      .tok_o        (tok[i]),
      .hit_o        (hit[i]),
      .ent_o        (ent[i])
    );
  end

  always_comb begin
    rep          = '0;
    table_packed = 1'b1;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      rep.hit   = rep.hit | hit[i];
      rep.conn  = rep.conn | (hit[i] ? ent[i].conn : '0);
      rep.heart = rep.heart | (hit[i] ? ent[i].heart : '0);
    end
    for (int i = 0; i + 1 < MAX_ENTRIES; i++) begin
      if (!ent[i].valid && ent[i+1].valid) begin
        table_packed = 1'b0;
      end
    end
  end

  hlt_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .action_i         (action_i),
    .connection_id_i  (connection_id_i),
    .station_id_i     (station_id_i),
    .initial_heart_i  (initial_heart_i),
    .limit_i          (limit_q),
    .rep_i            (rep),
    .packed_i         (table_packed),
    .cmd_o            (cmd),
    .busy_o           (busy),
    .result_valid_o   (result_valid_o),
    .status_o         (status_o),
    .connection_out_o (connection_out_o),
    .heart_out_o      (heart_out_o),
    .occupancy_o      (occupancy_o),
    .last_o           (last_o)
  );

`ifndef NO_ASSERTIONS
  a_idle_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> table_packed)
    else $error("Table has a hole while idle.");

  a_single_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rep.hit |-> cmd.walk)
    else $error("Hit reported outside a walk.");

  a_add_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && action_i == OP_ADD) |=> result_valid_o)
    else $error("Add request gave no result in the next cycle.");
`endif

endmodule

// ===== rtl/hlt_cell.sv =====
// ----------------------------------------------------------------------------
// hlt_cell
// One table slot. It holds an entry, takes a search token from its left
// neighbor and hands it on, and during compaction pulls the entry of its
// right neighbor into a hole.
// ----------------------------------------------------------------------------
module hlt_cell
  import hlt_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cmd_t   cmd_i,
  input  logic   left_valid_i,
  input  entry_t right_i,
  input  logic   tok_i,
  output logic   tok_o,
  output logic   hit_o,
  output entry_t ent_o
);

  logic               valid_q, valid_d;
  logic               tok_q;
  logic [ID_W-1:0]    conn_q, conn_d;
  logic [ID_W-1:0]    station_q, station_d;
  logic [HEART_W-1:0] heart_q, heart_d;
  logic               act;
  logic               match;
  logic               consume;

  assign act = tok_q & cmd_i.walk & valid_q;

  always_comb begin
    unique case (cmd_i.op)
      OP_REMOVE: match = (conn_q == cmd_i.conn);
      OP_CLEAR,
      OP_LOOKUP: match = (station_q == cmd_i.station);
      OP_SWEEP:  match = (heart_q >= cmd_i.limit) & cmd_i.drop_en;
      default:   match = 1'b0;
    endcase
  end

  assign hit_o   = act & match;
  assign consume = hit_o & (cmd_i.op != OP_SWEEP);
  assign tok_o   = tok_q & cmd_i.walk & ~consume;

  always_comb begin
    valid_d   = valid_q;
    conn_d    = conn_q;
    station_d = station_q;
    heart_d   = heart_q;
    priority if (cmd_i.compact) begin
      if (!valid_q) begin
        valid_d   = right_i.valid;
        conn_d    = right_i.conn;
        station_d = right_i.station;
        heart_d   = right_i.heart;
      end else if (!left_valid_i) begin
        valid_d = 1'b0;
      end
    end else if (cmd_i.wr && !valid_q && left_valid_i) begin
      valid_d   = 1'b1;
      conn_d    = cmd_i.conn;
      station_d = cmd_i.station;
      heart_d   = cmd_i.heart;
    end else if (cmd_i.tick && valid_q && heart_q != HEART_MAX) begin
      heart_d = heart_q + 1'b1;
    end else if (hit_o) begin
      if (cmd_i.op == OP_CLEAR) begin
        heart_d = '0;
      end else if (cmd_i.op == OP_REMOVE || cmd_i.op == OP_SWEEP) begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_i;
    end
  end

  always_ff @(posedge clk_i) begin
    conn_q    <= conn_d;
    station_q <= station_d;
    heart_q   <= heart_d;
  end

  assign ent_o = '{valid: valid_q, conn: conn_q, station: station_q, heart: heart_q};

endmodule

// ===== rtl/hlt_ctrl.sv =====
// ----------------------------------------------------------------------------
// hlt_ctrl
// Sequencer of the table. It decodes a request, runs actions that need no walk
// directly, walks a token along the cells for searches and sweeps, keeps the
// entry count, and drives the registered result strobe.
// ----------------------------------------------------------------------------
module hlt_ctrl
  import hlt_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 16
)(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [2:0]         action_i,
  input  logic [ID_W-1:0]    connection_id_i,
  input  logic [ID_W-1:0]    station_id_i,
  input  logic [HEART_W-1:0] initial_heart_i,
  input  logic [HEART_W-1:0] limit_i,
  input  rep_t               rep_i,
  input  logic               packed_i,
  output cmd_t               cmd_o,
  output logic               busy_o,
  output logic               result_valid_o,
  output logic [1:0]         status_o,
  output logic [ID_W-1:0]    connection_out_o,
  output logic [HEART_W-1:0] heart_out_o,
  output logic [OCC_W-1:0]   occupancy_o,
  output logic               last_o
);

  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  function automatic logic [OCC_W-1:0] occ_of(input logic [CW-1:0] c);
    logic [OCC_W+CW-1:0] t;
    t = {{OCC_W{1'b0}}, c};
    return t[OCC_W-1:0];
  endfunction

  st_e                st_q, st_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [CW-1:0]      len_q, len_d;
  logic [CW-1:0]      step_q, step_d;
  logic [KCNT_W-1:0]  k_q, k_d;
  op_e                op_q, op_d;
  logic [ID_W-1:0]    key_conn_q, key_conn_d;
  logic [ID_W-1:0]    key_station_q, key_station_d;
  logic               pend_v_q, pend_v_d;
  logic [ID_W-1:0]    pend_conn_q, pend_conn_d;
  logic [CW-1:0]      pend_occ_q, pend_occ_d;

  logic               emit;
  stat_e              e_status;
  logic [ID_W-1:0]    e_conn;
  logic [HEART_W-1:0] e_heart;
  logic [OCC_W-1:0]   e_occ;
  logic               e_last;

  logic               res_valid_q;
  logic [1:0]         status_q;
  logic [ID_W-1:0]    conn_out_q;
  logic [HEART_W-1:0] heart_out_q;
  logic [OCC_W-1:0]   occ_q;
  logic               last_q;

  logic accept, is_add, is_tick, is_unused, full, empty, walk_go, last_step;
  logic is_sweep;

  assign accept    = start_i & (st_q == ST_IDLE);
  assign is_add    = (action_i == OP_ADD);
  assign is_tick   = (action_i == OP_TICK);
  assign is_unused = (action_i > OP_LOOKUP);
  assign full      = (cnt_q == CW'(MAX_ENTRIES));
  assign empty     = (cnt_q == '0);
  assign walk_go   = accept & ~is_add & ~is_unused & ~is_tick & ~empty;
  assign last_step = (step_q == CW'(len_q - 1'b1));
  assign is_sweep  = (op_q == OP_SWEEP);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: begin
        if (walk_go) begin
          st_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (is_sweep) begin
          if (last_step) begin
            st_d = ST_FLUSH;
          end
        end else if (rep_i.hit) begin
          st_d = (op_q == OP_REMOVE) ? ST_COMPACT : ST_IDLE;
        end else if (last_step) begin
          st_d = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        st_d = pend_v_q ? ST_COMPACT : ST_IDLE;
      end
      ST_COMPACT: begin
        if (packed_i) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_d         = cnt_q;
    len_d         = len_q;
    step_d        = step_q;
    k_d           = k_q;
    op_d          = op_q;
    key_conn_d    = key_conn_q;
    key_station_d = key_station_q;
    pend_v_d      = pend_v_q;
    pend_conn_d   = pend_conn_q;
    pend_occ_d    = pend_occ_q;
    emit          = 1'b0;
    e_status      = STAT_OK;
    e_conn        = '0;
    e_heart       = '0;
    e_occ         = occ_of(cnt_q);
    e_last        = 1'b1;

    cmd_o.start   = walk_go;
    cmd_o.walk    = (st_q == ST_WALK);
    cmd_o.compact = (st_q == ST_COMPACT);
    cmd_o.tick    = accept & is_tick & ~empty;
    cmd_o.wr      = accept & is_add & ~full;
    cmd_o.drop_en = (k_q < KCNT_W'(MAX_RESULTS));
    cmd_o.op      = op_q;
    cmd_o.conn    = (st_q == ST_IDLE) ? connection_id_i : key_conn_q;
    cmd_o.station = (st_q == ST_IDLE) ? station_id_i : key_station_q;
    cmd_o.heart   = initial_heart_i;
    cmd_o.limit   = limit_i;

    unique case (st_q)
      ST_IDLE: begin
        if (accept) begin
          if (is_add) begin
            emit = 1'b1;
            if (full) begin
              e_status = STAT_FULL;
            end else begin
              cnt_d = CW'(cnt_q + 1'b1);
              e_occ = occ_of(CW'(cnt_q + 1'b1));
            end
          end else if (is_unused) begin
            emit = 1'b1;
          end else if (empty) begin
            emit     = 1'b1;
            e_status = STAT_EMPTY;
          end else if (is_tick) begin
            emit = 1'b1;
          end else begin
            op_d          = op_e'(action_i);
            key_conn_d    = connection_id_i;
            key_station_d = station_id_i;
            len_d         = cnt_q;
            step_d        = '0;
            k_d           = '0;
            pend_v_d      = 1'b0;
          end
        end
      end
      ST_WALK: begin
        if (!last_step) begin
          step_d = CW'(step_q + 1'b1);
        end
        if (is_sweep) begin
          if (rep_i.hit) begin
            cnt_d       = CW'(cnt_q - 1'b1);
            k_d         = KCNT_W'(k_q + 1'b1);
            pend_v_d    = 1'b1;
            pend_conn_d = rep_i.conn;
            pend_occ_d  = CW'(cnt_q - 1'b1);
            if (pend_v_q) begin
              emit   = 1'b1;
              e_conn = pend_conn_q;
              e_occ  = occ_of(pend_occ_q);
              e_last = 1'b0;
            end
          end
        end else if (rep_i.hit) begin
          emit = 1'b1;
          if (op_q == OP_REMOVE) begin
            cnt_d = CW'(cnt_q - 1'b1);
            e_occ = occ_of(CW'(cnt_q - 1'b1));
          end else if (op_q == OP_LOOKUP) begin
            e_conn  = rep_i.conn;
            e_heart = rep_i.heart;
          end
        end else if (last_step) begin
          emit     = 1'b1;
          e_status = STAT_NOTFOUND;
        end
      end
      ST_FLUSH: begin
        emit     = 1'b1;
        pend_v_d = 1'b0;
        if (pend_v_q) begin
          e_conn = pend_conn_q;
          e_occ  = occ_of(pend_occ_q);
        end else begin
          e_status = STAT_NOTFOUND;
        end
      end
      ST_COMPACT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      cnt_q       <= '0;
      len_q       <= '0;
      step_q      <= '0;
      k_q         <= '0;
      pend_v_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      cnt_q       <= cnt_d;
      len_q       <= len_d;
      step_q      <= step_d;
      k_q         <= k_d;
      pend_v_q    <= pend_v_d;
      res_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q          <= op_d;
    key_conn_q    <= key_conn_d;
    key_station_q <= key_station_d;
    pend_conn_q   <= pend_conn_d;
    pend_occ_q    <= pend_occ_d;
    status_q      <= e_status;
    conn_out_q    <= e_conn;
    heart_out_q   <= e_heart;
    occ_q         <= e_occ;
    last_q        <= e_last;
  end

  assign busy_o           = (st_q != ST_IDLE);
  assign result_valid_o   = res_valid_q;
  assign status_o         = status_q;
  assign connection_out_o = conn_out_q;
  assign heart_out_o      = heart_out_q;
  assign occupancy_o      = occ_q;
  assign last_o           = last_q;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_ENTRIES))
    else $error("Entry count exceeds the table depth.");

  a_drop_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_q <= KCNT_W'(MAX_RESULTS))
    else $error("Sweep dropped more entries than allowed.");

  a_search_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_WALK && op_q != OP_SWEEP && rep_i.hit) |=> (st_q != ST_WALK))
    else $error("Search walk continued after a hit.");

  a_sweep_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_WALK && op_q == OP_SWEEP && rep_i.hit)
      |=> (CW'(cnt_q + 1'b1) == $past(cnt_q)))
    else $error("Sweep drop did not reduce the entry count.");
`endif

endmodule
